>>> rtl/core/key_debounce_long_press_defines.svh
// assertion macros used by the checker file of the key debounce block
// no dependencies; the user's module must provide clk and rst_n
`ifndef KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// property checked at every edge outside reset
`define KDLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define KDLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/kdlp_pkg.sv
// shared types, register map and key codes of the key debounce block
// no dependencies
package kdlp_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int CNT_W   = 10;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SCAN_INTERVAL = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] REG_LONG_LIMIT    = 2'd2;
    localparam logic [1:0] REG_SHORT_LIMIT   = 2'd3;

    // register reset values
    localparam logic [7:0]       RST_SCAN_INTERVAL = 8'd5;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE      = 10'd4;
    localparam logic [CNT_W-1:0] RST_LONG_LIMIT    = 10'd1000;
    localparam logic [CNT_W-1:0] RST_SHORT_LIMIT   = 10'd500;

    // transaction kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // key codes
    localparam logic [7:0] KEY_MASK    = 8'hF8;
    localparam logic [7:0] KEY_NONE    = 8'h00;
    localparam logic [7:0] KEY_SPECIAL = 8'h08;
    localparam logic [7:0] KEY_4       = 8'h10;
    localparam logic [7:0] KEY_5       = 8'h20;
    localparam logic [7:0] KEY_6       = 8'h40;
    localparam logic [7:0] KEY_7       = 8'h80;
    localparam logic [7:0] CODE_LONG   = 8'h06;

    typedef struct packed {
        logic [7:0]       scan_interval;
        logic [CNT_W-1:0] debounce_count;
        logic [CNT_W-1:0] long_press_limit;
        logic [CNT_W-1:0] short_press_limit;
    } kdlp_cfg_t;

    typedef struct packed {
        logic [7:0]       scan_divider;
        logic [7:0]       last_key;
        logic [CNT_W-1:0] hold_count;
        logic [7:0]       pending_code;
        logic             code_ready;
    } kdlp_state_t;

    // no key or exactly one of the scanned keys
    function automatic logic single_or_none(input logic [7:0] k);
        return (k == KEY_NONE) || (k == KEY_SPECIAL) || (k == KEY_4) ||
               (k == KEY_5) || (k == KEY_6) || (k == KEY_7);
    endfunction

endpackage

>>> rtl/core/key_debounce_long_press.sv
// Key debounce with long press, top level. Every transaction is captured
// in an input register and applied to the key state when it leaves that
// register, so one transaction per cycle is sustained while the input does
// not stall. A tick gives no result. A read's code is loaded into a
// one-entry output register as the read leaves the input register. The
// input stalls only while a read sits in the input register and the output
// register still holds a result not yet taken; a tick queued behind such a
// read waits with it. The single state update stage lies between the input
// and output registers.
// Configuration via the APB port should be written with the block idle.
// depends on kdlp_pkg, kdlp_regs, kdlp_step
module key_debounce_long_press (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdlp_pkg::PADDR_W-1:0]  paddr,
    input  logic [kdlp_pkg::PDATA_W-1:0]  pwdata,
    output logic [kdlp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [7:0]                    tick_amount,
    input  logic [7:0]                    raw_lines,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    key_code
);
    import kdlp_pkg::*;

    kdlp_cfg_t   cfg;
    kdlp_state_t st_reg;
    kdlp_state_t st_next;
    logic [7:0]  read_code;

    logic        stg_valid_reg;
    logic        stg_kind_reg;
    logic [7:0]  stg_tick_reg;
    logic [7:0]  stg_raw_reg;
    logic        stg_advance;
    logic        in_fire;

    logic        out_valid_reg;
    logic [7:0]  out_code_reg;

    assign pready = 1'b1;

    kdlp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    kdlp_step u_step (
        .cfg         (cfg),
        .cur         (st_reg),
        .kind        (stg_kind_reg),
        .tick_amount (stg_tick_reg),
        .raw_lines   (stg_raw_reg),
        .nxt         (st_next),
        .read_code   (read_code)
    );

    // a tick always retires; a read needs room in the output register
    assign stg_advance = stg_valid_reg &&
                         ((stg_kind_reg == KIND_TICK) || !out_valid_reg || out_ready);
    assign in_ready    = !stg_valid_reg || stg_advance;
    assign in_fire     = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stg_kind_reg <= kind;
            stg_tick_reg <= tick_amount;
            stg_raw_reg  <= raw_lines;
        end
    end

    // key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (stg_advance)
        begin
            st_reg <= st_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_advance && (stg_kind_reg == KIND_READ))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_advance && (stg_kind_reg == KIND_READ))
        begin
            out_code_reg <= read_code;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = out_code_reg;

endmodule

>>> rtl/core/kdlp_regs.sv
// configuration register file behind the APB-style port
// depends on kdlp_pkg
module kdlp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdlp_pkg::PADDR_W-1:0]  paddr,
    input  logic [kdlp_pkg::PDATA_W-1:0]  pwdata,
    output logic [kdlp_pkg::PDATA_W-1:0]  prdata,
    output kdlp_pkg::kdlp_cfg_t           cfg
);
    import kdlp_pkg::*;

    kdlp_cfg_t  cfg_reg;
    kdlp_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SCAN_INTERVAL: cfg_next.scan_interval     = pwdata[7:0];
                REG_DEBOUNCE:      cfg_next.debounce_count    = pwdata[CNT_W-1:0];
                REG_LONG_LIMIT:    cfg_next.long_press_limit  = pwdata[CNT_W-1:0];
                REG_SHORT_LIMIT:   cfg_next.short_press_limit = pwdata[CNT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_interval     <= RST_SCAN_INTERVAL;
            cfg_reg.debounce_count    <= RST_DEBOUNCE;
            cfg_reg.long_press_limit  <= RST_LONG_LIMIT;
            cfg_reg.short_press_limit <= RST_SHORT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read-back mux
    always_comb
    begin
        case (reg_idx)
            REG_SCAN_INTERVAL: prdata = {{(PDATA_W-8){1'b0}}, cfg_reg.scan_interval};
            REG_DEBOUNCE:      prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.debounce_count};
            REG_LONG_LIMIT:    prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.long_press_limit};
            REG_SHORT_LIMIT:   prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.short_press_limit};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/kdlp_step.sv
// next-state logic for one transaction: scan divider, debounce and read-out
// depends on kdlp_pkg
module kdlp_step (
    input  kdlp_pkg::kdlp_cfg_t   cfg,
    input  kdlp_pkg::kdlp_state_t cur,
    input  logic                  kind,
    input  logic [7:0]            tick_amount,
    input  logic [7:0]            raw_lines,
    output kdlp_pkg::kdlp_state_t nxt,
    output logic [7:0]            read_code
);
    import kdlp_pkg::*;

    logic [7:0]       div_sum;
    logic             scan_hit;
    logic [7:0]       key;
    logic [CNT_W:0]   cnt_inc;
    logic             at_limit;
    logic [CNT_W-1:0] cnt_sat;
    logic             short_rel;

    assign div_sum  = cur.scan_divider + tick_amount;
    assign scan_hit = (div_sum >= cfg.scan_interval);
    assign key      = ~raw_lines & KEY_MASK;

    // held count, saturating at the long-press limit
    assign cnt_inc  = {1'b0, cur.hold_count} + {{CNT_W{1'b0}}, 1'b1};
    assign at_limit = (cnt_inc >= {1'b0, cfg.long_press_limit});
    assign cnt_sat  = at_limit ? cfg.long_press_limit : cnt_inc[CNT_W-1:0];

    // special key released after a short press
    assign short_rel = (cur.last_key == KEY_SPECIAL) &&
                       (cur.hold_count >= cfg.debounce_count) &&
                       (cur.hold_count < cfg.short_press_limit);

    always_comb
    begin
        nxt       = cur;
        read_code = KEY_NONE;
        if (kind == KIND_READ)
        begin
            // hand out the pending code once
            if (cur.code_ready)
            begin
                read_code      = cur.pending_code;
                nxt.code_ready = 1'b0;
            end
        end
        else
        begin
            nxt.scan_divider = scan_hit ? 8'd0 : div_sum;
            if (scan_hit && single_or_none(key))
            begin
                if (key == cur.last_key)
                begin
                    // same key still held
                    if (key != KEY_NONE)
                    begin
                        nxt.hold_count = cnt_sat;
                        if (key == KEY_SPECIAL)
                        begin
                            if (at_limit)
                            begin
                                nxt.pending_code = CODE_LONG;
                                nxt.code_ready   = 1'b1;
                            end
                        end
                        else if (cnt_sat == cfg.debounce_count)
                        begin
                            nxt.pending_code = key;
                            nxt.code_ready   = 1'b1;
                        end
                    end
                end
                else
                begin
                    // key changed
                    if (short_rel)
                    begin
                        nxt.pending_code = KEY_SPECIAL;
                        nxt.code_ready   = 1'b1;
                    end
                    nxt.last_key   = key;
                    nxt.hold_count = '0;
                end
            end
        end
    end

endmodule

>>> rtl/core/kdlp_checker.sv
// port-level checks for the key debounce block, bound to the top level
// depends on kdlp_pkg and key_debounce_long_press_defines.svh
`include "key_debounce_long_press_defines.svh"

module kdlp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [kdlp_pkg::PADDR_W-1:0]  paddr,
    input logic [kdlp_pkg::PDATA_W-1:0]  pwdata,
    input logic [kdlp_pkg::PDATA_W-1:0]  prdata,
    input logic                          pready,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          kind,
    input logic [7:0]                    tick_amount,
    input logic [7:0]                    raw_lines,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [7:0]                    key_code
);
    import kdlp_pkg::*;

    logic out_stall;
    logic code_ok;

    assign out_stall = out_valid && !out_ready;

    // codes the block can deliver
    assign code_ok = (key_code == KEY_NONE) || (key_code == CODE_LONG) ||
                     (key_code == KEY_SPECIAL) || (key_code == KEY_4) ||
                     (key_code == KEY_5) || (key_code == KEY_6) || (key_code == KEY_7);

    // a stalled result stays put
    `KDLP_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(key_code), "stalled result changed")

    // only known codes ever leave the block
    `KDLP_ASSERT(a_code_known, out_valid |-> code_ok, "unexpected key code")

    // with the output side empty the input side never stalls
    `KDLP_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty output")

    // nothing is delivered straight out of reset
    `KDLP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (.*);
